[hdl/vertical_boxcar_line_smoother_assert.svh]
// Assertion macros shared by the vertical boxcar smoother RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef VERTICAL_BOXCAR_LINE_SMOOTHER_ASSERT_SVH
`define VERTICAL_BOXCAR_LINE_SMOOTHER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define VBLS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define VBLS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/vbls_pkg.sv]
// Shared types and constants for the vertical boxcar smoother.
// No dependencies.
`default_nettype none

package vbls_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int SUM_W        = 12;
  localparam int ROW_W        = 16;
  localparam int LINE_WIDTH_W = 13;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;
  localparam int FIFO_CW      = 3;

  localparam logic [ROW_W-1:0]        ROW_MAX          = '1;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd4096;

  // Word index of the line width register (paddr bit 2).
  localparam logic REG_LINE_WIDTH = 1'b0;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  typedef struct packed {
    logic valid;
    logic drain;
    logic sum_zero;
    logic sub_old;
    logic emit_raw;
    logic emit_smooth;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_sample;
    logic                passed_raw;
    logic                drain_last;
  } res_t;

endpackage

`default_nettype wire

[hdl/vbls_ctrl.sv]
// Sequencer of the vertical boxcar smoother: line width register, column, row,
// ring slot and drain counters, and memory address generation. Uses vbls_pkg.
`default_nettype none

module vbls_ctrl import vbls_pkg::*; #(
  parameter int KERNEL_ROWS = 5,
  parameter int MAX_WIDTH   = 4096,
  localparam int AW = $clog2(KERNEL_ROWS * MAX_WIDTH),
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_we,
  input  wire  [LINE_WIDTH_W-1:0] cfg_wdata,
  output logic [LINE_WIDTH_W-1:0] line_width,
  input  wire                     accept,
  input  wire                     mode,
  input  wire  [SAMPLE_W-1:0]     sample,
  output ctl_t                    req,
  output logic [AW-1:0]           store_addr,
  output logic [CW-1:0]           sum_addr,
  output logic [SAMPLE_W-1:0]     req_sample
);

  localparam int HALF = KERNEL_ROWS / 2;
  localparam int SW   = $clog2(KERNEL_ROWS);
  localparam int PW   = $clog2(HALF + 1);

  logic [LINE_WIDTH_W-1:0] line_width_next;
  logic [CW-1:0]           width_last, width_last_next;
  logic [CW-1:0]           column_index, column_index_next;
  logic [ROW_W-1:0]        row_index, row_index_next;
  logic [SW-1:0]           ring_slot, ring_slot_next;
  logic [CW-1:0]           drain_col, drain_col_next;
  logic [PW-1:0]           drain_line, drain_line_next;

  logic [PW-1:0] pending;
  logic          drain_active;
  logic          drain_end;
  logic [SW:0]   drain_slot_raw;
  logic [SW-1:0] drain_slot;
  logic [31:0]   eff_width;
  logic          restart;

  always_comb begin
    if (row_index < ROW_W'(HALF)) begin
      pending = '0;
    end else if (row_index < ROW_W'(2 * HALF)) begin
      pending = PW'(row_index - ROW_W'(HALF));
    end else begin
      pending = PW'(HALF);
    end
  end

  assign drain_active = (drain_col != '0) || (drain_line != '0);
  assign drain_end    = (drain_line == PW'(pending - PW'(1))) && (drain_col == width_last);

  always_comb begin
    drain_slot_raw = (SW+1)'(ring_slot) + (SW+1)'(KERNEL_ROWS) - (SW+1)'(pending)
                   + (SW+1)'(drain_line);
    if (drain_slot_raw >= (SW+1)'(KERNEL_ROWS)) begin
      drain_slot = SW'(drain_slot_raw - (SW+1)'(KERNEL_ROWS));
    end else begin
      drain_slot = SW'(drain_slot_raw);
    end
  end

  always_comb begin
    eff_width = 32'(cfg_wdata);
    if (eff_width == 32'd0) begin
      eff_width = 32'd1;
    end else if (eff_width > 32'(MAX_WIDTH)) begin
      eff_width = 32'(MAX_WIDTH);
    end
  end

  always_comb begin
    line_width_next   = line_width;
    width_last_next   = width_last;
    column_index_next = column_index;
    row_index_next    = row_index;
    ring_slot_next    = ring_slot;
    drain_col_next    = drain_col;
    drain_line_next   = drain_line;
    restart           = 1'b0;
    if (cfg_we) begin
      line_width_next = cfg_wdata;
      width_last_next = CW'(eff_width - 32'd1);
      restart         = 1'b1;
    end else if (accept) begin
      if (mode == MODE_DRAIN) begin
        if ((pending == '0) || drain_end) begin
          restart = 1'b1;
        end else if (drain_col == width_last) begin
          drain_col_next  = '0;
          drain_line_next = drain_line + PW'(1);
        end else begin
          drain_col_next = drain_col + CW'(1);
        end
      end else if (!drain_active) begin
        if (column_index == width_last) begin
          column_index_next = '0;
          if (row_index != ROW_MAX) begin
            row_index_next = row_index + ROW_W'(1);
          end
          if (ring_slot == SW'(KERNEL_ROWS - 1)) begin
            ring_slot_next = '0;
          end else begin
            ring_slot_next = ring_slot + SW'(1);
          end
        end else begin
          column_index_next = column_index + CW'(1);
        end
      end
    end
    if (restart) begin
      column_index_next = '0;
      row_index_next    = '0;
      ring_slot_next    = '0;
      drain_col_next    = '0;
      drain_line_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RESET;
      width_last   <= CW'(MAX_WIDTH - 1);
      column_index <= '0;
      row_index    <= '0;
      ring_slot    <= '0;
      drain_col    <= '0;
      drain_line   <= '0;
    end else begin
      line_width   <= line_width_next;
      width_last   <= width_last_next;
      column_index <= column_index_next;
      row_index    <= row_index_next;
      ring_slot    <= ring_slot_next;
      drain_col    <= drain_col_next;
      drain_line   <= drain_line_next;
    end
  end

  always_comb begin
    req.valid       = accept && ((mode == MODE_DRAIN) ? (pending != '0) : !drain_active);
    req.drain       = (mode == MODE_DRAIN);
    req.sum_zero    = (row_index == '0);
    req.sub_old     = (row_index >= ROW_W'(KERNEL_ROWS));
    req.emit_raw    = (row_index < ROW_W'(HALF));
    req.emit_smooth = (row_index >= ROW_W'(2 * HALF));
    req.last        = drain_end;
    if (mode == MODE_DRAIN) begin
      store_addr = AW'(drain_slot) * AW'(MAX_WIDTH) + AW'(drain_col);
    end else begin
      store_addr = AW'(ring_slot) * AW'(MAX_WIDTH) + AW'(column_index);
    end
    sum_addr   = column_index;
    req_sample = sample;
  end

`include "vertical_boxcar_line_smoother_assert.svh"

  `VBLS_ASSERT_NOW(a_col_in_line, 1'b1, column_index <= width_last, "column index past line end")
  `VBLS_ASSERT_NOW(a_drain_has_rows, drain_active, pending != '0, "drain running with no rows")

endmodule

`default_nettype wire

[hdl/vbls_datapath.sv]
// Line store and column-sum memories with read-modify-write, forwarding and the
// divide-by-kernel stage of the vertical boxcar smoother. Uses vbls_pkg.
`default_nettype none

module vbls_datapath import vbls_pkg::*; #(
  parameter int KERNEL_ROWS = 5,
  parameter int MAX_WIDTH   = 4096,
  localparam int AW = $clog2(KERNEL_ROWS * MAX_WIDTH),
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire                 clk,
  input  wire                 rst,
  input  ctl_t                req,
  input  wire  [AW-1:0]       store_addr,
  input  wire  [CW-1:0]       sum_addr,
  input  wire  [SAMPLE_W-1:0] req_sample,
  output res_t                res,
  output logic                res_valid,
  output logic [1:0]          in_flight
);

  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = 24;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((1 << DIV_SHIFT) + KERNEL_ROWS - 1) / KERNEL_ROWS);

  logic [SAMPLE_W-1:0] store_mem [KERNEL_ROWS * MAX_WIDTH];
  logic [SUM_W-1:0]    sum_mem   [MAX_WIDTH];

  logic [SAMPLE_W-1:0] store_rd;
  logic [SUM_W-1:0]    sum_rd;

  ctl_t                s1;
  logic [AW-1:0]       s1_store_addr;
  logic [CW-1:0]       s1_sum_addr;
  logic [SAMPLE_W-1:0] s1_sample;

  logic                store_we;
  logic                sum_we;
  logic [SUM_W-1:0]    sum_new;
  logic [SAMPLE_W-1:0] store_val;
  logic [SUM_W-1:0]    sum_val;

  logic                store_fwd_v;
  logic [AW-1:0]       store_fwd_a;
  logic [SAMPLE_W-1:0] store_fwd_d;
  logic                sum_fwd_v;
  logic [CW-1:0]       sum_fwd_a;
  logic [SUM_W-1:0]    sum_fwd_d;

  logic                s2_valid;
  logic                s2_smooth;
  logic                s2_raw;
  logic                s2_last;
  logic [SUM_W-1:0]    s2_value;
  logic [SUM_W+RECIP_W-1:0] product;

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[s1_store_addr] <= s1_sample;
    end
    store_rd <= store_mem[store_addr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[s1_sum_addr] <= sum_new;
    end
    sum_rd <= sum_mem[sum_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid    <= 1'b0;
      store_fwd_v <= 1'b0;
      sum_fwd_v   <= 1'b0;
    end else begin
      s1.valid    <= req.valid;
      store_fwd_v <= store_we;
      sum_fwd_v   <= sum_we;
    end
    s1.drain       <= req.drain;
    s1.sum_zero    <= req.sum_zero;
    s1.sub_old     <= req.sub_old;
    s1.emit_raw    <= req.emit_raw;
    s1.emit_smooth <= req.emit_smooth;
    s1.last        <= req.last;
    s1_store_addr  <= store_addr;
    s1_sum_addr    <= sum_addr;
    s1_sample      <= req_sample;
    store_fwd_a    <= s1_store_addr;
    store_fwd_d    <= s1_sample;
    sum_fwd_a      <= s1_sum_addr;
    sum_fwd_d      <= sum_new;
  end

  always_comb begin
    if (store_fwd_v && (store_fwd_a == s1_store_addr)) begin
      store_val = store_fwd_d;
    end else begin
      store_val = store_rd;
    end
    if (s1.sum_zero) begin
      sum_val = '0;
    end else if (sum_fwd_v && (sum_fwd_a == s1_sum_addr)) begin
      sum_val = sum_fwd_d;
    end else begin
      sum_val = sum_rd;
    end
    sum_new  = sum_val - (s1.sub_old ? SUM_W'(store_val) : '0) + SUM_W'(s1_sample);
    store_we = s1.valid && !s1.drain;
    sum_we   = s1.valid && !s1.drain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1.valid && (s1.drain || s1.emit_raw || s1.emit_smooth);
    end
    s2_smooth <= !s1.drain && !s1.emit_raw;
    s2_raw    <= s1.drain || s1.emit_raw;
    s2_last   <= s1.drain && s1.last;
    if (s1.drain) begin
      s2_value <= SUM_W'(store_val);
    end else if (s1.emit_raw) begin
      s2_value <= SUM_W'(s1_sample);
    end else begin
      s2_value <= sum_new;
    end
  end

  always_comb begin
    product   = (SUM_W+RECIP_W)'(s2_value) * (SUM_W+RECIP_W)'(DIV_RECIP);
    res_valid = s2_valid;
    res.passed_raw = s2_raw;
    res.drain_last = s2_last;
    if (s2_smooth) begin
      res.out_sample = product[DIV_SHIFT +: SAMPLE_W];
    end else begin
      res.out_sample = s2_value[SAMPLE_W-1:0];
    end
    in_flight = 2'(s1.valid) + 2'(s2_valid);
  end

`include "vertical_boxcar_line_smoother_assert.svh"

  `VBLS_ASSERT_NEXT(a_drain_emits, s1.valid && s1.drain, s2_valid && s2_raw, "drain word lost")

endmodule

`default_nettype wire

[hdl/vbls_out_fifo.sv]
// Small result queue that decouples the smoother pipeline from output stalls.
// Uses vbls_pkg.
`default_nettype none

module vbls_out_fifo import vbls_pkg::*; (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  res_t               push_data,
  output logic               out_valid,
  input  wire                out_ready,
  output res_t               out_data,
  output logic [FIFO_CW-1:0] count
);

  res_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

`include "vertical_boxcar_line_smoother_assert.svh"

  `VBLS_ASSERT_NOW(a_no_overflow, push, count < FIFO_CW'(FIFO_DEPTH), "result queue overflow")

endmodule

`default_nettype wire

[hdl/vertical_boxcar_line_smoother.sv]
// Top level of the vertical boxcar smoother: stream ports, APB register port,
// admission control. Instantiates vbls_ctrl, vbls_datapath, vbls_out_fifo.
//
// Streams an 8-bit image in row-major order and returns, per column, the
// truncated mean of KERNEL_ROWS lines. The first KERNEL_ROWS/2 rows pass through
// raw; smoothed rows follow KERNEL_ROWS/2 lines late; drain words (tuser = 1)
// then return the buffered tail rows raw, tlast on the final one. One word is
// accepted per clock while the output queue has room: the line store and the
// column-sum memory each take one read and one write per cycle, with forwarding
// between neighbors. Words pass registers s1 and s2; a four-entry output queue
// absorbs stalls. No clearing pass runs after reset: the column sums read as
// zero throughout the first row. Write line_width only while the block is idle.
`default_nettype none

module vertical_boxcar_line_smoother import vbls_pkg::*; #(
  parameter int KERNEL_ROWS = 5,
  parameter int MAX_WIDTH   = 4096
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [7:0]            s_axis_tdata,  // [7:0] sample
  input  wire  [0:0]            s_axis_tuser,  // [0] mode
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // [7:0] out_sample
  output logic [0:0]            m_axis_tuser,  // [0] passed_raw
  output logic                  m_axis_tlast,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [APB_ADDR_W-1:0] paddr,
  input  wire  [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(KERNEL_ROWS * MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH);

  logic                    cfg_we;
  logic [LINE_WIDTH_W-1:0] line_width;
  logic                    accept;
  ctl_t                    req;
  logic [AW-1:0]           store_addr;
  logic [CW-1:0]           sum_addr;
  logic [SAMPLE_W-1:0]     req_sample;
  res_t                    res;
  logic                    res_valid;
  logic [1:0]              in_flight;
  res_t                    out_data;
  logic [FIFO_CW-1:0]      fifo_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_LINE_WIDTH);
  assign prdata = (paddr[2] == REG_LINE_WIDTH) ? APB_DATA_W'(line_width) : '0;

  assign s_axis_tready = (4'(fifo_count) + 4'(in_flight)) < 4'(FIFO_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  vbls_ctrl #(
    .KERNEL_ROWS (KERNEL_ROWS),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata[LINE_WIDTH_W-1:0]),
    .line_width (line_width),
    .accept     (accept),
    .mode       (s_axis_tuser[0]),
    .sample     (s_axis_tdata),
    .req        (req),
    .store_addr (store_addr),
    .sum_addr   (sum_addr),
    .req_sample (req_sample)
  );

  vbls_datapath #(
    .KERNEL_ROWS (KERNEL_ROWS),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .store_addr (store_addr),
    .sum_addr   (sum_addr),
    .req_sample (req_sample),
    .res        (res),
    .res_valid  (res_valid),
    .in_flight  (in_flight)
  );

  vbls_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  assign m_axis_tdata    = out_data.out_sample;
  assign m_axis_tuser[0] = out_data.passed_raw;
  assign m_axis_tlast    = out_data.drain_last;

endmodule

`default_nettype wire
